// ===== rtl/lhcd_pkg.sv =====
// Shared types, constants and the CRC16-CCITT-FALSE byte update for the deframer.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package lhcd_pkg;

    localparam logic [2:0]  HDR_BYTES = 3'd5;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_START = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data;
        logic       data_valid;
        logic [7:0] packet_id;
        logic [7:0] payload_offset;
        logic       last;
        logic       crc_ok;
    } res_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/lhcd_core.sv =====
// Input register, header hunt and payload tracking of the deframer.
// Depends on lhcd_pkg for the result type, the header size and the CRC update.
`timescale 1ns / 1ps

module lhcd_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          rx_byte,
    input  logic                rx_valid,
    output logic                rx_stall,
    input  logic                take_ok,
    output lhcd_pkg::res_t      res,
    output logic                res_valid
);

    logic        byte_valid_reg;
    logic [7:0]  byte_reg;
    logic        take;

    logic        in_packet_reg, in_packet_next;
    logic [31:0] window_reg, window_next;
    logic [2:0]  fill_reg, fill_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] crc_exp_reg, crc_exp_next;
    logic [15:0] crc_run_reg, crc_run_next;

    logic [2:0]  fill_inc;
    logic [7:0]  hdr_sum;
    logic [15:0] crc_new;
    logic [7:0]  count_inc;

    // The held word is consumed whenever the result register can take its outcome.
    assign take     = byte_valid_reg && take_ok;
    assign rx_stall = byte_valid_reg && !take_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (rx_valid && !rx_stall)
        begin
            byte_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            byte_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
        begin
            byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg <= 1'b0;
            window_reg    <= '0;
            fill_reg      <= '0;
            length_reg    <= '0;
            count_reg     <= '0;
            id_reg        <= '0;
            crc_exp_reg   <= '0;
            crc_run_reg   <= lhcd_pkg::CRC_START;
        end
        else
        begin
            in_packet_reg <= in_packet_next;
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            length_reg    <= length_next;
            count_reg     <= count_next;
            id_reg        <= id_next;
            crc_exp_reg   <= crc_exp_next;
            crc_run_reg   <= crc_run_next;
        end
    end

    assign fill_inc  = (fill_reg == lhcd_pkg::HDR_BYTES) ? fill_reg : fill_reg + 3'd1;
    assign hdr_sum   = window_reg[31:24] + window_reg[23:16] + window_reg[15:8]
                       + window_reg[7:0] + byte_reg;
    assign crc_new   = lhcd_pkg::crc_byte(crc_run_reg, byte_reg);
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        in_packet_next = in_packet_reg;
        window_next    = window_reg;
        fill_next      = fill_reg;
        length_next    = length_reg;
        count_next     = count_reg;
        id_next        = id_reg;
        crc_exp_next   = crc_exp_reg;
        crc_run_next   = crc_run_reg;
        res            = '0;
        res_valid      = 1'b0;

        if (take)
        begin
            if (!in_packet_reg)
            begin
                window_next = {window_reg[23:0], byte_reg};
                fill_next   = fill_inc;
                // A header is found when the LRC byte and the four bytes after it sum to zero.
                if (fill_inc == lhcd_pkg::HDR_BYTES && hdr_sum == 8'd0)
                begin
                    id_next      = window_reg[23:16];
                    length_next  = window_reg[15:8];
                    crc_exp_next = {byte_reg, window_reg[7:0]};
                    window_next  = '0;
                    fill_next    = '0;
                    count_next   = '0;
                    crc_run_next = lhcd_pkg::CRC_START;
                    if (window_reg[15:8] == 8'd0)
                    begin
                        res_valid     = 1'b1;
                        res.packet_id = window_reg[23:16];
                        res.last      = 1'b1;
                        res.crc_ok    = ({byte_reg, window_reg[7:0]} == lhcd_pkg::CRC_START);
                    end
                    else
                    begin
                        in_packet_next = 1'b1;
                    end
                end
            end
            else
            begin
                res_valid          = 1'b1;
                res.data           = byte_reg;
                res.data_valid     = 1'b1;
                res.packet_id      = id_reg;
                res.payload_offset = count_reg;
                if (count_inc >= length_reg)
                begin
                    res.last       = 1'b1;
                    res.crc_ok     = (crc_new == crc_exp_reg);
                    in_packet_next = 1'b0;
                    window_next    = '0;
                    fill_next      = '0;
                    count_next     = '0;
                    crc_run_next   = lhcd_pkg::CRC_START;
                end
                else
                begin
                    count_next   = count_inc;
                    crc_run_next = crc_new;
                end
            end
        end
    end

endmodule

// ===== rtl/lhcd_out_reg.sv =====
// Result register of the deframer, holding one finished word for the receiver.
// Depends on lhcd_pkg for the result type.
`timescale 1ns / 1ps

module lhcd_out_reg
(
    input  logic            clk,
    input  logic            rst_n,
    input  lhcd_pkg::res_t  res,
    input  logic            res_valid,
    output logic            take_ok,
    output lhcd_pkg::res_t  res_out,
    output logic            result_valid,
    input  logic            result_stall
);

    logic           valid_reg;
    lhcd_pkg::res_t res_reg;

    assign take_ok      = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign res_out      = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take_ok)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_ok && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

// ===== rtl/lrc_header_crc16_packet_deframer.sv =====
// An accepted byte is held in the input register; any result word for it is then loaded
// into the result register. Throughput: one byte per cycle while result_stall is low;
// the input register and the result register each hold one word, and the byte register
// frees whenever the result register can load. Reset clears all control state at once;
// no clearing pass is needed. Depends on lhcd_pkg, lhcd_core and lhcd_out_reg.
`timescale 1ns / 1ps

module lrc_header_crc16_packet_deframer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic       rx_valid,
    output logic       rx_stall,
    output logic [7:0] data,
    output logic       data_valid,
    output logic [7:0] packet_id,
    output logic [7:0] payload_offset,
    output logic       last,
    output logic       crc_ok,
    output logic       result_valid,
    input  logic       result_stall
);

    lhcd_pkg::res_t res;
    lhcd_pkg::res_t res_out;
    logic           res_valid;
    logic           take_ok;

    lhcd_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (rx_byte),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .take_ok   (take_ok),
        .res       (res),
        .res_valid (res_valid)
    );

    lhcd_out_reg u_out_reg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .res          (res),
        .res_valid    (res_valid),
        .take_ok      (take_ok),
        .res_out      (res_out),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    assign data           = res_out.data;
    assign data_valid     = res_out.data_valid;
    assign packet_id      = res_out.packet_id;
    assign payload_offset = res_out.payload_offset;
    assign last           = res_out.last;
    assign crc_ok         = res_out.crc_ok;

endmodule
